[src/tph_pkg.sv]
// Shared types and constants for the timeline playhead block.
// No dependencies; used by tph_mod and timeline_playhead_with_cue_events.
package tph_pkg;

  localparam int TIME_W    = 22;             // playhead and cue times, 1/4096 s
  localparam int DELTA_W   = 16;
  localparam int SPEED_W   = 12;             // 8 fraction bits
  localparam int SPEED_FRAC = 8;
  localparam int PROD_W    = DELTA_W + SPEED_W;
  localparam int STEP_W    = PROD_W - SPEED_FRAC;
  localparam int SUM_W     = TIME_W + 1;     // playhead + step never overflows this
  localparam int SUM_CNT_W = $clog2(SUM_W);
  localparam int CUE_COUNT = 16;
  localparam int CUE_IDX_W = $clog2(CUE_COUNT);
  localparam int MASK_W    = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [2:0] {
    MODE_TICK   = 3'd0,
    MODE_PLAY   = 3'd1,
    MODE_PAUSE  = 3'd2,
    MODE_RESUME = 3'd3,
    MODE_STOP   = 3'd4,
    MODE_SEEK   = 3'd5,
    MODE_CUE    = 3'd6
  } mode_t;

  typedef enum logic [1:0] {
    WRAP_HOLD = 2'd0,
    WRAP_LOOP = 2'd1,
    WRAP_NONE = 2'd2
  } wrap_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DURATION = 3'd0,
    CFG_INIT     = 3'd1,
    CFG_SPEED    = 3'd2,
    CFG_WRAP     = 3'd3,
    CFG_EMIT     = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SUM,
    ST_MOD,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [2:0]        mode;
    logic [DELTA_W-1:0] delta;
    logic [TIME_W-1:0] time_value;
    logic [3:0]        cue_index;
    logic              cue_enable;
    logic              reset_time;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0] current_time;
    logic              playing;
    logic              paused;
    logic              wrapped;
    logic              finished;
    logic [MASK_W-1:0] fired_mask;
  } result_t;

  // handshake between sequencer and modulo unit
  typedef struct packed {
    logic start;
  } mod_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_sts_t;

endpackage

[src/tph_mod.sv]
// Iterative restoring modulo unit: one quotient bit per cycle.
// Depends on tph_pkg.
module tph_mod (
  input  logic                        clk,
  input  logic                        rst,
  input  tph_pkg::mod_ctl_t           ctl,
  input  logic [tph_pkg::SUM_W-1:0]   dividend,
  input  logic [tph_pkg::TIME_W-1:0]  divisor,
  output tph_pkg::mod_sts_t           sts,
  output logic [tph_pkg::TIME_W-1:0]  remainder
);

  logic                          busy;
  logic                          done;
  logic [tph_pkg::SUM_CNT_W-1:0] cnt;
  logic [tph_pkg::SUM_W-1:0]     dvd;
  logic [tph_pkg::TIME_W-1:0]    dsr;
  logic [tph_pkg::TIME_W-1:0]    rem;
  logic [tph_pkg::SUM_W-1:0]     shifted;
  logic [tph_pkg::SUM_W-1:0]     diff;
  logic                          ge;
  logic                          last;

  // rem < dsr, so the shifted partial remainder fits SUM_W bits
  assign shifted = {rem, dvd[tph_pkg::SUM_W-1]};
  assign ge      = shifted >= {1'b0, dsr};
  assign diff    = shifted - {1'b0, dsr};
  assign last    = (cnt == tph_pkg::SUM_CNT_W'(tph_pkg::SUM_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && last;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (last) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= {dvd[tph_pkg::SUM_W-2:0], 1'b0};
      rem <= ge ? diff[tph_pkg::TIME_W-1:0] : shifted[tph_pkg::TIME_W-1:0];
    end
  end

  assign sts.busy  = busy;
  assign sts.done  = done;
  assign remainder = rem;

endmodule

[src/timeline_playhead_with_cue_events.sv]
// Timeline playhead: transport commands, speed-scaled ticks, wrap handling, cue firing.
// Play/pause/resume/stop/seek/cue write/idle tick pass through EXEC, then FINISH, to result.
// A moving tick passes EXEC and SUM, then the loop-mode modulo unit on a wrap, then the
// one-cue-per-cycle scan over all CUE_COUNT (16) entries when cues are enabled, then FINISH.
// One word in flight; item_stall stays high until the result is loaded into the output reg.
// rst (synchronous) clears flags, playhead, cue enables and fired marks; config to defaults.
module timeline_playhead_with_cue_events (
  input  logic                            clk,
  input  logic                            rst,
  // config write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tph_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tph_pkg::TIME_W-1:0]      cfg_data,
  // item channel
  input  logic                            item_valid,
  output logic                            item_stall,
  input  tph_pkg::item_t                  item,
  // result channel
  output logic                            result_valid,
  input  logic                            result_stall,
  output tph_pkg::result_t                result
);

  // ---------------- configuration ----------------
  logic [tph_pkg::TIME_W-1:0]  duration;
  logic [tph_pkg::TIME_W-1:0]  initial_time;
  logic [tph_pkg::SPEED_W-1:0] speed;
  logic [1:0]                  wrap_mode;
  logic                        emit_cues;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      duration     <= tph_pkg::TIME_W'(4096);
      initial_time <= '0;
      speed        <= tph_pkg::SPEED_W'(256);
      wrap_mode    <= tph_pkg::WRAP_HOLD;
      emit_cues    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tph_pkg::CFG_DURATION: duration     <= cfg_data;
        tph_pkg::CFG_INIT:     initial_time <= cfg_data;
        tph_pkg::CFG_SPEED:    speed        <= cfg_data[tph_pkg::SPEED_W-1:0];
        tph_pkg::CFG_WRAP:     wrap_mode    <= cfg_data[1:0];
        tph_pkg::CFG_EMIT:     emit_cues    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ---------------- state ----------------
  tph_pkg::state_t state, state_next;

  tph_pkg::item_t              item_r;      // latched word
  logic [tph_pkg::TIME_W-1:0]  playhead;
  logic                        run_flag;
  logic                        pause_flag;
  logic [tph_pkg::TIME_W-1:0]  prev_time;   // playhead before the tick
  logic [tph_pkg::STEP_W-1:0]  step;
  logic                        wrap_hit;    // this tick wrapped (loop mode)
  logic                        fin_hit;
  logic [tph_pkg::MASK_W-1:0]  mask;
  logic [tph_pkg::CUE_IDX_W-1:0] scan_idx;

  // cue table: written at one index, read at the scan index only
  logic [tph_pkg::TIME_W-1:0]    cue_time [tph_pkg::CUE_COUNT];
  logic [tph_pkg::CUE_COUNT-1:0] cue_enabled;
  logic [tph_pkg::CUE_COUNT-1:0] cue_fired;

  function automatic logic [tph_pkg::TIME_W-1:0] clamp_dur(
    input logic [tph_pkg::TIME_W-1:0] t,
    input logic [tph_pkg::TIME_W-1:0] d
  );
    return (t > d) ? d : t;
  endfunction

  // ---------------- datapath helpers ----------------
  logic [tph_pkg::PROD_W-1:0] prod;
  logic [tph_pkg::SUM_W-1:0]  sum;
  logic                       past_end;
  logic                       tick_live;
  logic                       last_cue;

  // step = floor(delta * speed / 256)
  assign prod      = tph_pkg::PROD_W'(item_r.delta) * tph_pkg::PROD_W'(speed);
  assign sum       = {1'b0, playhead} + tph_pkg::SUM_W'(step);
  assign past_end  = sum > {1'b0, duration};
  assign tick_live = run_flag && !pause_flag && (duration != '0);
  assign last_cue  = (scan_idx == tph_pkg::CUE_IDX_W'(tph_pkg::CUE_COUNT - 1));

  // cue window test for the entry under the scan pointer
  logic [tph_pkg::TIME_W-1:0] cue_c;
  logic                       cue_live;
  logic                       cue_fire;
  logic                       after_prev;
  logic                       upto_cur;

  assign cue_c      = clamp_dur(cue_time[scan_idx], duration);
  assign cue_live   = cue_enabled[scan_idx] && !cue_fired[scan_idx];
  assign after_prev = cue_c > prev_time;
  assign upto_cur   = cue_c <= playhead;
  // window split in two on a wrapped tick
  assign cue_fire   = cue_live && (wrap_hit ? (after_prev || upto_cur)
                                            : (after_prev && upto_cur));

  // ---------------- modulo unit ----------------
  tph_pkg::mod_ctl_t          mod_ctl;
  tph_pkg::mod_sts_t          mod_sts;
  logic [tph_pkg::TIME_W-1:0] mod_rem;

  assign mod_ctl.start = (state == tph_pkg::ST_SUM) && (step != '0) && past_end
                         && (wrap_mode == tph_pkg::WRAP_LOOP);

  tph_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .ctl       (mod_ctl),
    .dividend  (sum),
    .divisor   (duration),
    .sts       (mod_sts),
    .remainder (mod_rem)
  );

  // ---------------- sequencer ----------------
  logic out_load;

  assign item_stall = (state != tph_pkg::ST_IDLE);
  assign out_load   = (state == tph_pkg::ST_FINISH) && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tph_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tph_pkg::ST_IDLE: begin
        if (item_valid) begin
          state_next = tph_pkg::ST_EXEC;
        end
      end
      tph_pkg::ST_EXEC: begin
        if (item_r.mode == tph_pkg::MODE_TICK && tick_live) begin
          state_next = tph_pkg::ST_SUM;
        end else begin
          state_next = tph_pkg::ST_FINISH;
        end
      end
      tph_pkg::ST_SUM: begin
        if (step == '0) begin
          state_next = tph_pkg::ST_FINISH;
        end else if (past_end && wrap_mode == tph_pkg::WRAP_LOOP) begin
          state_next = tph_pkg::ST_MOD;
        end else if (past_end && wrap_mode == tph_pkg::WRAP_NONE) begin
          state_next = tph_pkg::ST_FINISH;
        end else if (emit_cues) begin
          state_next = tph_pkg::ST_SCAN;
        end else begin
          state_next = tph_pkg::ST_FINISH;
        end
      end
      tph_pkg::ST_MOD: begin
        if (mod_sts.done) begin
          state_next = emit_cues ? tph_pkg::ST_SCAN : tph_pkg::ST_FINISH;
        end
      end
      tph_pkg::ST_SCAN: begin
        if (last_cue) begin
          state_next = tph_pkg::ST_FINISH;
        end
      end
      tph_pkg::ST_FINISH: begin
        if (out_load) begin
          state_next = tph_pkg::ST_IDLE;
        end
      end
      default: state_next = tph_pkg::ST_IDLE;
    endcase
  end

  // control flags, playhead, cue enables and fired marks
  always_ff @(posedge clk) begin
    if (rst) begin
      playhead    <= '0;
      run_flag    <= 1'b0;
      pause_flag  <= 1'b0;
      cue_enabled <= '0;
      cue_fired   <= '0;
    end else begin
      case (state)
        tph_pkg::ST_EXEC: begin
          case (item_r.mode)
            tph_pkg::MODE_PLAY: begin
              if (playhead == '0 || playhead >= duration) begin
                playhead <= clamp_dur(initial_time, duration);
              end
              run_flag   <= 1'b1;
              pause_flag <= 1'b0;
              cue_fired  <= '0;
            end
            tph_pkg::MODE_PAUSE: begin
              if (run_flag) begin
                pause_flag <= 1'b1;
              end
            end
            tph_pkg::MODE_RESUME: begin
              if (run_flag) begin
                pause_flag <= 1'b0;
              end
            end
            tph_pkg::MODE_STOP: begin
              run_flag   <= 1'b0;
              pause_flag <= 1'b0;
              if (item_r.reset_time) begin
                playhead <= clamp_dur(initial_time, duration);
              end
            end
            tph_pkg::MODE_SEEK: begin
              playhead <= clamp_dur(item_r.time_value, duration);
            end
            tph_pkg::MODE_CUE: begin
              if (32'(item_r.cue_index) < tph_pkg::CUE_COUNT) begin
                cue_enabled[item_r.cue_index[tph_pkg::CUE_IDX_W-1:0]] <= item_r.cue_enable;
              end
            end
            default: ;
          endcase
        end
        tph_pkg::ST_SUM: begin
          if (step != '0) begin
            if (!past_end) begin
              playhead <= sum[tph_pkg::TIME_W-1:0];
            end else if (wrap_mode == tph_pkg::WRAP_NONE) begin
              playhead   <= duration;
              run_flag   <= 1'b0;
              pause_flag <= 1'b0;
            end else if (wrap_mode != tph_pkg::WRAP_LOOP) begin
              // hold, and the unused code behaves as hold
              playhead   <= duration;
              run_flag   <= 1'b0;
              pause_flag <= 1'b1;
            end
          end
        end
        tph_pkg::ST_MOD: begin
          if (mod_sts.done) begin
            playhead  <= mod_rem;
            cue_fired <= '0;
          end
        end
        tph_pkg::ST_SCAN: begin
          if (cue_fire) begin
            cue_fired[scan_idx] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (state)
      tph_pkg::ST_IDLE: begin
        item_r   <= item;
        wrap_hit <= 1'b0;
        fin_hit  <= 1'b0;
        mask     <= '0;
        scan_idx <= '0;
      end
      tph_pkg::ST_EXEC: begin
        step <= prod[tph_pkg::PROD_W-1:tph_pkg::SPEED_FRAC];
        if (item_r.mode == tph_pkg::MODE_CUE
            && 32'(item_r.cue_index) < tph_pkg::CUE_COUNT) begin
          cue_time[item_r.cue_index[tph_pkg::CUE_IDX_W-1:0]] <= item_r.time_value;
        end
      end
      tph_pkg::ST_SUM: begin
        prev_time <= playhead;
        if (step != '0 && past_end) begin
          wrap_hit <= (wrap_mode == tph_pkg::WRAP_LOOP);
          fin_hit  <= (wrap_mode == tph_pkg::WRAP_NONE);
        end
      end
      tph_pkg::ST_SCAN: begin
        scan_idx <= scan_idx + 1'b1;
        if (cue_fire && 32'(scan_idx) < tph_pkg::MASK_W) begin
          mask[scan_idx] <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result.current_time <= playhead;
      result.playing      <= run_flag;
      result.paused       <= pause_flag;
      result.wrapped      <= wrap_hit;
      result.finished     <= fin_hit;
      result.fired_mask   <= mask;
    end
  end

  // ---------------- checks ----------------
  a_wrap_fin_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.wrapped && result.finished))
    else $error("wrapped and finished both set");

  a_fin_stopped: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.finished |-> !result.playing && !result.paused && result.fired_mask == '0)
    else $error("finished tick left playback running or fired cues");

  a_wrap_playing: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.wrapped |-> result.playing && !result.paused)
    else $error("wrapped tick stopped playback");

  a_mod_done_state: assert property (@(posedge clk) disable iff (rst)
    mod_sts.done |-> state == tph_pkg::ST_MOD)
    else $error("modulo unit finished outside its wait state");

endmodule
